>>> rtl/nrd_pkg.sv
// shared constants for the non-restoring divider
`timescale 1ns / 1ps
package nrd_pkg;

  localparam int FIELD_W = 32;
  localparam int MAX_W   = 64;

endpackage

>>> rtl/nrd_cell.sv
// one non-restoring division step with its pipeline register
`timescale 1ns / 1ps
module nrd_cell #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [WIDTH:0]   up_a,
  input  logic [WIDTH-1:0] up_q,
  input  logic [WIDTH-1:0] up_d,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [WIDTH:0]   dn_a,
  output logic [WIDTH-1:0] dn_q,
  output logic [WIDTH-1:0] dn_d
);

  logic             valid;
  logic [WIDTH:0]   a;
  logic [WIDTH-1:0] q;
  logic [WIDTH-1:0] d;
  logic [WIDTH:0]   a_shift;
  logic [WIDTH:0]   a_next;
  logic [WIDTH-1:0] q_next;

  assign up_ready = !valid || dn_ready;
  assign a_shift  = {up_a[WIDTH-1:0], up_q[WIDTH-1]};
  assign a_next   = up_a[WIDTH] ? a_shift + {1'b0, up_d} : a_shift - {1'b0, up_d};
  assign q_next   = {up_q[WIDTH-2:0], ~a_next[WIDTH]};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      a <= a_next;
      q <= q_next;
      d <= up_d;
    end
  end

  assign dn_valid = valid;
  assign dn_a     = a;
  assign dn_q     = q;
  assign dn_d     = d;

endmodule

>>> rtl/nrd_fix.sv
// final remainder correction and output register
`timescale 1ns / 1ps
module nrd_fix #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  logic [WIDTH:0]   up_a,
  input  logic [WIDTH-1:0] up_q,
  input  logic [WIDTH-1:0] up_d,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [WIDTH-1:0] dn_q,
  output logic [WIDTH-1:0] dn_r
);

  logic             valid;
  logic [WIDTH-1:0] q;
  logic [WIDTH-1:0] r;
  logic [WIDTH:0]   r_next;

  assign up_ready = !valid || dn_ready;
  assign r_next   = up_a[WIDTH] ? up_a + {1'b0, up_d} : up_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      q <= up_q;
      r <= r_next[WIDTH-1:0];
    end
  end

  assign dn_valid = valid;
  assign dn_q     = q;
  assign dn_r     = r;

endmodule

>>> rtl/nonrestoring_unsigned_divider.sv
// top level: pipelined non-restoring unsigned divider, one cell per quotient bit
//
//   channel | handshake             | payload
//   --------+-----------------------+----------------------
//   request | req_valid / req_ready | dividend, divisor
//   result  | res_valid / res_ready | quotient, remainder
//
// one request per cycle while the chain is not stalled; WIDTH step cells, one correction stage
// each cell holds while the next one is full and stalled; bubbles collapse along the chain
// a stalled result backs up the chain one stage at a time
// reset clears the valid bits only
`timescale 1ns / 1ps
module nonrestoring_unsigned_divider #(
  parameter int WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [nrd_pkg::FIELD_W-1:0] dividend,
  input  logic [nrd_pkg::FIELD_W-1:0] divisor,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [nrd_pkg::FIELD_W-1:0] quotient,
  output logic [nrd_pkg::FIELD_W-1:0] remainder
);

  import nrd_pkg::*;

  logic [MAX_W-1:0] n_ext;
  logic [MAX_W-1:0] d_ext;
  logic [MAX_W-1:0] q_ext;
  logic [MAX_W-1:0] r_ext;
  logic [WIDTH-1:0] q_out;
  logic [WIDTH-1:0] r_out;

  logic [WIDTH:0]   vld;
  logic [WIDTH:0]   rdy;
  logic [WIDTH:0]   a_c [WIDTH+1];
  logic [WIDTH-1:0] q_c [WIDTH+1];
  logic [WIDTH-1:0] d_c [WIDTH+1];

  assign n_ext = MAX_W'(dividend);
  assign d_ext = MAX_W'(divisor);

  assign vld[0]    = req_valid;
  assign req_ready = rdy[0];
  assign a_c[0]    = '0;
  assign q_c[0]    = n_ext[WIDTH-1:0];
  assign d_c[0]    = d_ext[WIDTH-1:0];

  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    nrd_cell #(.WIDTH(WIDTH)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (vld[i]),
      .up_ready (rdy[i]),
      .up_a     (a_c[i]),
      .up_q     (q_c[i]),
      .up_d     (d_c[i]),
      .dn_valid (vld[i+1]),
      .dn_ready (rdy[i+1]),
      .dn_a     (a_c[i+1]),
      .dn_q     (q_c[i+1]),
      .dn_d     (d_c[i+1])
    );
  end

  nrd_fix #(.WIDTH(WIDTH)) u_fix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (vld[WIDTH]),
    .up_ready (rdy[WIDTH]),
    .up_a     (a_c[WIDTH]),
    .up_q     (q_c[WIDTH]),
    .up_d     (d_c[WIDTH]),
    .dn_valid (res_valid),
    .dn_ready (res_ready),
    .dn_q     (q_out),
    .dn_r     (r_out)
  );

  assign q_ext     = MAX_W'(q_out);
  assign r_ext     = MAX_W'(r_out);
  assign quotient  = q_ext[FIELD_W-1:0];
  assign remainder = r_ext[FIELD_W-1:0];

  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> vld[1] && res_valid && !res_ready)
    else $error("request refused while the chain has room");

  a_zero_divisor_positive: assert property (@(posedge clk) disable iff (rst)
    vld[WIDTH] && d_c[WIDTH] == '0 |-> !a_c[WIDTH][WIDTH])
    else $error("negative partial remainder with a zero divisor");

  a_full_chain_blocks: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready && (&vld[WIDTH:1]) |-> !req_ready)
    else $error("request taken while every stage is full");

endmodule
